// File: rtl/dma_command_stream_decoder_top_macros.svh
// Assertion macros shared by the DMA command stream decoder RTL.
`ifndef DMA_COMMAND_STREAM_DECODER_TOP_MACROS_SVH
`define DMA_COMMAND_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked only while reset is released.
`define DCSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcsd assertion failed");

// Next-cycle implication, checked only while reset is released.
`define DCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcsd assertion failed");

`endif

// File: rtl/dcsd_pkg.sv
// Shared types and constants of the DMA command stream decoder.
package dcsd_pkg;

  localparam int unsigned SLOT_QUEUE_DEPTH_DEF = 4;
  localparam int unsigned OP_FIFO_DEPTH_DEF    = 2;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SLOT_W = 3;

  // Parameter slot codes.
  localparam logic [SLOT_W-1:0] SLOT_A_LO    = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_A_HI    = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_LEN_LO  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_LEN_HI  = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_B_LO    = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_B_HI    = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_DISCARD = 3'd7;

  typedef enum logic [1:0] {
    OP_PARAM,
    OP_DIR,
    OP_FIRE
  } op_kind_e;

  // One operation handed from the decoder to the register file.
  typedef struct packed {
    op_kind_e          kind;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] data;
  } op_t;

endpackage

// File: rtl/dma_command_stream_decoder_top.sv
// Top level of the DMA command stream decoder.
// A fire item passes the operation queue, then the result register, to the master side.
// Throughput: one item per cycle, set by the one-op-per-cycle queue and register file.
// Programming bytes produce no result. A stalled result holds the queue once a fire
// op reaches its head, and the slave side stalls when the queue is full.
// Reset: rst_ni is asynchronous and active low; addresses, length, direction,
// the pending slot count and the operation queue are cleared, outputs go invalid.
`include "dma_command_stream_decoder_top_macros.svh"

module dma_command_stream_decoder_top import dcsd_pkg::*; #(
  parameter int unsigned SLOT_QUEUE_DEPTH = SLOT_QUEUE_DEPTH_DEF,
  parameter int unsigned OP_FIFO_DEPTH    = OP_FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] mode (1 = fire transfer)
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // [15:0] source_address, [31:16] dest_address,
                                        // [47:32] byte_count
);

  // The front end decides, per item, whether a byte is a parameter or a new
  // command, since that depends only on its own pending slot queue. Anything
  // that touches the DMA registers, or a fire request, is passed on as an
  // operation, so ordering between register updates and fires is preserved.
  logic fe_op_valid, fe_op_ready;
  op_t  fe_op;
  logic be_op_valid, be_op_ready;
  op_t  be_op;
  logic [ADDR_W-1:0] source, dest, count;

  // Helper terms for the checks at the end of the module.
  logic in_fire_accept, fire_pop, be_fire_waiting, out_stalled;

  dcsd_front #(
    .SLOT_QUEUE_DEPTH(SLOT_QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_mode_i  (s_axis_tuser_i[0]),
    .in_byte_i  (s_axis_tdata_i),
    .op_valid_o (fe_op_valid),
    .op_ready_i (fe_op_ready),
    .op_o       (fe_op)
  );

  // The queue lets the decoder keep taking bytes while a result is stalled.
  dcsd_op_fifo #(
    .DEPTH(OP_FIFO_DEPTH)
  ) u_op_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_op_valid),
    .push_ready_o (fe_op_ready),
    .push_data_i  (fe_op),
    .pop_valid_o  (be_op_valid),
    .pop_ready_i  (be_op_ready),
    .pop_data_o   (be_op)
  );

  dcsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (be_op_valid),
    .op_ready_o  (be_op_ready),
    .op_i        (be_op),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .source_o    (source),
    .dest_o      (dest),
    .count_o     (count)
  );

  assign m_axis_tdata_o = {count, dest, source};

  assign in_fire_accept  = s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i[0];
  assign fire_pop        = be_op_valid && be_op_ready && (be_op.kind == OP_FIRE);
  assign be_fire_waiting = be_op_valid && (be_op.kind == OP_FIRE);
  assign out_stalled     = m_axis_tvalid_o && !m_axis_tready_i;

  // A fire item that was accepted is queued for the back end.
  `DCSD_ASSERT_NEXT(a_fire_queued, clk_i, rst_ni, in_fire_accept, be_op_valid)

  // A new result appears only after the back end took a fire operation.
  `DCSD_ASSERT_IMPL(a_result_from_fire, clk_i, rst_ni, $rose(m_axis_tvalid_o), $past(fire_pop))

  // A fire operation never overwrites a result that is still stalled.
  `DCSD_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, be_fire_waiting && out_stalled, !be_op_ready)

endmodule

// File: rtl/dcsd_front.sv
// Front end: accepts items, tracks pending parameter slots and decodes commands.
module dcsd_front import dcsd_pkg::*; #(
  parameter int unsigned SLOT_QUEUE_DEPTH = SLOT_QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_mode_i,
  input  logic [BYTE_W-1:0] in_byte_i,
  output logic              op_valid_o,
  input  logic              op_ready_i,
  output op_t               op_o
);

  localparam int unsigned CNT_W = $clog2(SLOT_QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(SLOT_QUEUE_DEPTH);

  logic [SLOT_W-1:0] slot_q [SLOT_QUEUE_DEPTH];
  logic [SLOT_W-1:0] slot_d [SLOT_QUEUE_DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;

  logic [SLOT_W-1:0] cand [4];
  logic [3:0]        cand_en;
  logic              is_wr0, is_wr12, is_wr3, is_wr4, is_wr5, is_wr6;
  logic              accept;
  logic              need_op;
  logic [CNT_W-1:0]  idx;

  assign in_ready_o = op_ready_i;
  assign accept     = in_valid_i && op_ready_i;
  assign op_valid_o = in_valid_i && need_op;

  // Command classes, checked in priority order below.
  always_comb begin
    is_wr0  = !in_byte_i[7] && (in_byte_i[1:0] != 2'b00);
    is_wr12 = ((in_byte_i & 8'h87) == 8'h04) || ((in_byte_i & 8'h87) == 8'h00);
    is_wr3  = (in_byte_i & 8'h83) == 8'h80;
    is_wr4  = (in_byte_i & 8'h83) == 8'h81;
    is_wr5  = (in_byte_i & 8'hc7) == 8'h82;
    is_wr6  = (in_byte_i & 8'h83) == 8'h83;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cand[k] = SLOT_DISCARD;
    end
    cand_en = 4'b0000;
    if (is_wr0) begin
      cand[0] = SLOT_A_LO;
      cand[1] = SLOT_A_HI;
      cand[2] = SLOT_LEN_LO;
      cand[3] = SLOT_LEN_HI;
      cand_en = in_byte_i[6:3];
    end else if (is_wr12) begin
      cand_en[0] = in_byte_i[6];
    end else if (is_wr3) begin
      cand_en[0] = in_byte_i[3];
      cand_en[1] = in_byte_i[4];
    end else if (is_wr4) begin
      cand[0]    = SLOT_B_LO;
      cand[1]    = SLOT_B_HI;
      cand_en[0] = in_byte_i[2];
      cand_en[1] = in_byte_i[3];
      cand_en[2] = in_byte_i[4];
    end else if (is_wr5) begin
      cand_en = 4'b0000;
    end else if (is_wr6) begin
      cand_en[0] = (in_byte_i == 8'hbb);
    end
  end

  always_comb begin
    slot_d  = slot_q;
    count_d = count_q;
    need_op = 1'b0;
    idx     = count_q;
    op_o.kind = OP_FIRE;
    op_o.slot = slot_q[0];
    op_o.data = in_byte_i;
    if (in_mode_i) begin
      need_op = 1'b1;
    end else if (count_q != '0) begin
      // Parameter byte: pop the oldest slot; discarded bytes go no further.
      op_o.kind = OP_PARAM;
      need_op   = (slot_q[0] != SLOT_DISCARD);
      if (accept) begin
        for (int i = 0; i + 1 < SLOT_QUEUE_DEPTH; i++) begin
          slot_d[i] = slot_q[i + 1];
        end
        count_d = count_q - CNT_W'(1);
      end
    end else begin
      op_o.kind = OP_DIR;
      need_op   = is_wr0;
      if (accept) begin
        for (int k = 0; k < 4; k++) begin
          if (cand_en[k] && (idx < CNT_W'(SLOT_QUEUE_DEPTH))) begin
            slot_d[idx[IDX_W-1:0]] = cand[k];
            idx = idx + CNT_W'(1);
          end
        end
        count_d = idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

// File: rtl/dcsd_op_fifo.sv
// Short operation queue between the decoder and the register file.
module dcsd_op_fifo import dcsd_pkg::*; #(
  parameter int unsigned DEPTH = OP_FIFO_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  op_t              mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/dcsd_back.sv
// Back end: DMA address, length and direction registers and the result register.
module dcsd_back import dcsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  input  op_t               op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] source_o,
  output logic [ADDR_W-1:0] dest_o,
  output logic [ADDR_W-1:0] count_o
);

  logic [ADDR_W-1:0] port_a_q, port_a_d;
  logic [ADDR_W-1:0] port_b_q, port_b_d;
  logic [ADDR_W-1:0] length_q, length_d;
  logic              dir_q, dir_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] source_q, dest_q, count_q;
  logic              pop, load_out;

  // A fire operation waits only while the result register is held.
  assign op_ready_o = (op_i.kind != OP_FIRE) || !out_valid_q || out_ready_i;
  assign pop        = op_valid_i && op_ready_o;
  assign load_out   = pop && (op_i.kind == OP_FIRE);

  always_comb begin
    port_a_d = port_a_q;
    port_b_d = port_b_q;
    length_d = length_q;
    dir_d    = dir_q;
    if (pop) begin
      case (op_i.kind)
        OP_DIR: begin
          dir_d = op_i.data[2];
        end
        OP_PARAM: begin
          case (op_i.slot)
            SLOT_A_LO:   port_a_d[7:0]  = op_i.data;
            SLOT_A_HI:   port_a_d[15:8] = op_i.data;
            SLOT_LEN_LO: length_d[7:0]  = op_i.data;
            SLOT_LEN_HI: length_d[15:8] = op_i.data;
            SLOT_B_LO:   port_b_d[7:0]  = op_i.data;
            SLOT_B_HI:   port_b_d[15:8] = op_i.data;
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q    <= '0;
      port_b_q    <= '0;
      length_q    <= '0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      port_a_q    <= port_a_d;
      port_b_q    <= port_b_d;
      length_q    <= length_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      source_q <= dir_q ? port_a_q : port_b_q;
      dest_q   <= dir_q ? port_b_q : port_a_q;
      count_q  <= length_q + ADDR_W'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign source_o    = source_q;
  assign dest_o      = dest_q;
  assign count_o     = count_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the DMA command stream decoder top level.
`timescale 1ns / 1ps

module tb;
  import dcsd_pkg::*;

  localparam logic MODE_PROGRAM = 1'b0;
  localparam logic MODE_FIRE    = 1'b1;

  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned QUIET_ITEMS  = 200;

  // One transfer as it appears on the master side.
  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] dest_address;
    logic [ADDR_W-1:0] byte_count;
  } transfer_t;

  // One directed item; the transfer is typed in only where it is obvious.
  typedef struct {
    logic        mode;
    logic [7:0]  data_byte;
    bit          typed;
    transfer_t   transfer;
  } directed_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] data_byte
  logic [0:0]  s_axis_tuser_i;   // [0] mode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;   // [15:0] source, [31:16] dest, [47:32] byte count

  // Shadow copy of the decoder registers.
  logic [ADDR_W-1:0] port_a_addr;
  logic [ADDR_W-1:0] port_b_addr;
  logic [ADDR_W-1:0] block_len;
  logic              a_to_b;
  logic [SLOT_W-1:0] param_slots[$];

  transfer_t      transfers_due[$];
  directed_item_t directed_items[$];
  int unsigned    accepted_items;
  int unsigned    mismatches;
  bit             quiet;
  int             sink_hold;

  dma_command_stream_decoder_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void queue_slot(input logic [SLOT_W-1:0] code);
    if (param_slots.size() < SLOT_QUEUE_DEPTH_DEF) param_slots.push_back(code);
  endfunction

  function automatic logic [ADDR_W-1:0] with_byte(input logic [ADDR_W-1:0] r,
                                                   input logic [7:0] b,
                                                   input bit upper);
    return upper ? {b, r[7:0]} : {r[15:8], b};
  endfunction

  // Classifies a command byte and queues the parameter bytes it asks for.
  function automatic void decode_command(input logic [7:0] b);
    case ({b[7], b[1:0]})
      3'b0_01, 3'b0_10, 3'b0_11: begin
        a_to_b = b[2];
        if (b[3]) queue_slot(SLOT_A_LO);
        if (b[4]) queue_slot(SLOT_A_HI);
        if (b[5]) queue_slot(SLOT_LEN_LO);
        if (b[6]) queue_slot(SLOT_LEN_HI);
      end
      3'b0_00: begin
        if (b[6]) queue_slot(SLOT_DISCARD);
      end
      3'b1_00: begin
        if (b[3]) queue_slot(SLOT_DISCARD);
        if (b[4]) queue_slot(SLOT_DISCARD);
      end
      3'b1_01: begin
        if (b[2]) queue_slot(SLOT_B_LO);
        if (b[3]) queue_slot(SLOT_B_HI);
        if (b[4]) queue_slot(SLOT_DISCARD);
      end
      default: begin
        // Bytes ending in 10 without bits 6 and 2 carry no parameters; the
        // rest of that group is ignored. Of the 11 group only one byte has one.
        if (b == 8'hBB) queue_slot(SLOT_DISCARD);
      end
    endcase
  endfunction

  // Advances the shadow registers by one item; returns the transfer a fire shows.
  function automatic transfer_t step_decoder(input logic mode, input logic [7:0] b);
    transfer_t t;
    logic [SLOT_W-1:0] code;
    t.source_address = a_to_b ? port_a_addr : port_b_addr;
    t.dest_address   = a_to_b ? port_b_addr : port_a_addr;
    t.byte_count     = block_len + 16'd1;
    if (mode == MODE_PROGRAM) begin
      if (param_slots.size() != 0) begin
        code = param_slots.pop_front();
        case (code)
          SLOT_A_LO:   port_a_addr = with_byte(port_a_addr, b, 1'b0);
          SLOT_A_HI:   port_a_addr = with_byte(port_a_addr, b, 1'b1);
          SLOT_LEN_LO: block_len   = with_byte(block_len, b, 1'b0);
          SLOT_LEN_HI: block_len   = with_byte(block_len, b, 1'b1);
          SLOT_B_LO:   port_b_addr = with_byte(port_b_addr, b, 1'b0);
          SLOT_B_HI:   port_b_addr = with_byte(port_b_addr, b, 1'b1);
          default: ;
        endcase
      end else begin
        decode_command(b);
      end
    end
    return t;
  endfunction

  // Results are checked before the input side is sampled, so a transfer is
  // never compared against an expectation pushed on the same edge.
  always @(posedge clk_i) begin : check_proc
    transfer_t want;
    transfer_t got;
    transfer_t calc;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[47:0];
        got.source_address = m_axis_tdata_o[15:0];
        got.dest_address   = m_axis_tdata_o[31:16];
        got.byte_count     = m_axis_tdata_o[47:32];
        if (transfers_due.size() == 0) begin
          report_mismatch("transfer shown with none due");
        end else begin
          want = transfers_due.pop_front();
          if (got.source_address !== want.source_address)
            report_mismatch($sformatf("source %h, want %h", got.source_address,
                                      want.source_address));
          if (got.dest_address !== want.dest_address)
            report_mismatch($sformatf("dest %h, want %h", got.dest_address,
                                      want.dest_address));
          if (got.byte_count !== want.byte_count)
            report_mismatch($sformatf("count %h, want %h", got.byte_count,
                                      want.byte_count));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        calc = step_decoder(s_axis_tuser_i[0], s_axis_tdata_i);
        if (s_axis_tuser_i[0] == MODE_FIRE) begin
          if (accepted_items < directed_items.size() && directed_items[accepted_items].typed)
            transfers_due.push_back(directed_items[accepted_items].transfer);
          else
            transfers_due.push_back(calc);
        end
        accepted_items++;
      end
    end
  end

  // Master side: ready in random bursts, held high once the run goes quiet.
  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready_i <= 1'b1;
      sink_hold       <= 0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      m_axis_tready_i <= 1'b1;
      sink_hold       <= $urandom_range(0, 30);
    end else begin
      m_axis_tready_i <= 1'b0;
      sink_hold       <= $urandom_range(0, 17);
    end
  end

  task automatic add_item(input logic mode, input logic [7:0] b);
    directed_item_t d;
    d.mode      = mode;
    d.data_byte = b;
    d.typed     = 1'b0;
    d.transfer  = '0;
    directed_items.push_back(d);
  endtask

  task automatic add_fire(input logic [15:0] src, input logic [15:0] dst,
                          input logic [15:0] cnt);
    directed_item_t d;
    d.mode      = MODE_FIRE;
    d.data_byte = 8'h00;
    d.typed     = 1'b1;
    d.transfer  = '{source_address: src, dest_address: dst, byte_count: cnt};
    directed_items.push_back(d);
  endtask

  // Holds one item on the slave side until it is accepted.
  task automatic send_item(input logic mode, input logic [7:0] b);
    s_axis_tvalid_i   <= 1'b1;
    s_axis_tuser_i[0] <= mode;
    s_axis_tdata_i    <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic idle_slave(input int unsigned cycles);
    s_axis_tvalid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned idle_pct;
    int unsigned pick;
    logic [7:0]  b;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    s_axis_tuser_i  <= 1'b0;
    m_axis_tready_i <= 1'b0;
    rst_ni          <= 1'b0;
    port_a_addr     = '0;
    port_b_addr     = '0;
    block_len       = '0;
    a_to_b          = 1'b0;
    accepted_items  = 0;
    mismatches      = 0;
    quiet           = 1'b0;
    sink_hold       = 0;

    // A fire straight after reset shows cleared registers and a count of one.
    add_fire(16'h0000, 16'h0000, 16'h0001);
    add_item(MODE_PROGRAM, 8'h79);   // WR0: A low/high, length low/high, B to A
    add_item(MODE_PROGRAM, 8'h34);
    add_item(MODE_PROGRAM, 8'h12);
    add_item(MODE_FIRE,    8'hFF);   // fire between parameters leaves the slots alone
    add_item(MODE_PROGRAM, 8'hFF);
    add_item(MODE_PROGRAM, 8'hFF);
    add_fire(16'h0000, 16'h1234, 16'h0000);   // length 0xFFFF wraps the count to zero
    add_item(MODE_PROGRAM, 8'h9D);   // WR4: B low, B high, one throwaway byte
    add_item(MODE_PROGRAM, 8'hCD);
    add_item(MODE_PROGRAM, 8'hAB);
    add_item(MODE_PROGRAM, 8'h77);
    add_item(MODE_PROGRAM, 8'h05);   // WR0 without parameters, A to B
    add_fire(16'h1234, 16'hABCD, 16'h0000);
    add_item(MODE_PROGRAM, 8'h44);   // WR1/WR2 with one throwaway byte
    add_item(MODE_PROGRAM, 8'h5A);
    add_item(MODE_PROGRAM, 8'h98);   // WR3 with two throwaway bytes
    add_item(MODE_PROGRAM, 8'h00);
    add_item(MODE_PROGRAM, 8'hFF);
    add_item(MODE_PROGRAM, 8'h82);   // WR5
    add_item(MODE_PROGRAM, 8'hBB);   // the one WR6 command with a parameter
    add_item(MODE_PROGRAM, 8'hFE);
    add_item(MODE_PROGRAM, 8'hC3);   // WR6 without a parameter
    add_item(MODE_PROGRAM, 8'hC6);   // matches no command and is ignored
    add_item(MODE_PROGRAM, 8'h61);   // WR0: length low/high, B to A
    add_item(MODE_PROGRAM, 8'h00);
    add_item(MODE_PROGRAM, 8'h00);
    add_fire(16'hABCD, 16'h1234, 16'h0001);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_items[i]) begin
      if ($urandom_range(0, 3) == 0) idle_slave($urandom_range(1, 18));
      send_item(directed_items[i].mode, directed_items[i].data_byte);
    end

    // Random part: commands that take parameters, so addresses and
    // length keep changing, mixed with fires and raw bytes.
    idle_pct = 25;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 99) < idle_pct) idle_slave($urandom_range(1, 18));
      pick = $urandom_range(0, 99);
      b    = 8'($urandom_range(0, 255));
      if (pick < 15) begin
        send_item(MODE_FIRE, b);
      end else if (pick < 40) begin
        b[7] = 1'b0;
        if (b[1:0] == 2'b00) b[0] = 1'b1;
        send_item(MODE_PROGRAM, b);
      end else if (pick < 55) begin
        b[7]   = 1'b1;
        b[1:0] = 2'b01;
        send_item(MODE_PROGRAM, b);
      end else begin
        send_item(MODE_PROGRAM, b);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (transfers_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && transfers_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dcsd_pkg.sv
rtl/dcsd_front.sv
rtl/dcsd_op_fifo.sv
rtl/dcsd_back.sv
rtl/dma_command_stream_decoder_top.sv
tb/tb.sv
